// ----- rtl/knnmc_pkg.sv -----
`timescale 1ns / 1ps
package knnmc_pkg;

  localparam int unsigned DefMaxReferences = 1024;
  localparam int unsigned DefMaxFeatures   = 16;
  localparam int unsigned DefMaxK          = 16;
  localparam int unsigned DefNumClasses    = 16;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned FeatW  = 16;
  localparam int unsigned LabelW = 4;
  localparam int unsigned CfgW   = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned VoteW  = 5;
  localparam int unsigned DistW  = 38;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_K        = 2'd0,
    REG_FEATURES = 2'd1,
    REG_CLASSES  = 2'd2,
    REG_NONE     = 2'd3
  } reg_e;

  typedef struct packed {
    logic [LabelW-1:0] predicted_class;
    logic [VoteW-1:0]  vote_count;
    logic              references_dropped;
  } result_t;

endpackage

// ----- rtl/knnmc_front.sv -----
`timescale 1ns / 1ps
module knnmc_front import knnmc_pkg::*; #(
  parameter int unsigned MAX_REFERENCES = DefMaxReferences,
  parameter int unsigned MAX_FEATURES   = DefMaxFeatures,
  localparam int unsigned AW  = (MAX_REFERENCES * MAX_FEATURES > 1) ?
                                $clog2(MAX_REFERENCES * MAX_FEATURES) : 1,
  localparam int unsigned RW  = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1,
  localparam int unsigned CNW = $clog2(MAX_REFERENCES + 1),
  localparam int unsigned PW  = $clog2(MAX_FEATURES + 1),
  localparam int unsigned QW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [CmdW-1:0]         cmd_i,
  input  logic signed [FeatW-1:0] feature_value_i,
  input  logic [LabelW-1:0]       label_i,
  input  logic                    last_element_i,
  output logic                    fwe_o,
  output logic [AW-1:0]           faddr_o,
  output logic signed [FeatW-1:0] fdata_o,
  output logic                    lwe_o,
  output logic [RW-1:0]           laddr_o,
  output logic [LabelW+PW-1:0]    ldata_o,
  output logic signed [FeatW-1:0] qbuf_o [MAX_FEATURES],
  output logic                    job_valid_o,
  output logic [PW-1:0]           job_qlen_o,
  output logic [CNW-1:0]          job_count_o,
  output logic                    job_dropped_o
);

  logic [CNW-1:0] count_q, count_d;
  logic [AW-1:0]  base_q, base_d;
  logic [PW-1:0]  pos_q, pos_d, pos_inc;
  logic           dropped_q, dropped_d;
  logic           job_q, job_d;
  logic [PW-1:0]  qlen_q, qlen_d;
  logic           room, slot_ok, is_load, is_query;
  logic signed [FeatW-1:0] qbuf_q [MAX_FEATURES];

  assign room     = count_q < CNW'(MAX_REFERENCES);
  assign slot_ok  = pos_q < PW'(MAX_FEATURES);
  assign pos_inc  = slot_ok ? pos_q + PW'(1) : pos_q;
  assign is_load  = accept_i && (cmd_i == CMD_LOAD);
  assign is_query = accept_i && (cmd_i == CMD_QUERY);

  assign fwe_o   = is_load && room && slot_ok;
  assign faddr_o = base_q + AW'(pos_q);
  assign fdata_o = feature_value_i;
  assign lwe_o   = is_load && room && last_element_i;
  assign laddr_o = RW'(count_q);
  assign ldata_o = {label_i, pos_inc};

  always_comb begin
    count_d   = count_q;
    base_d    = base_q;
    pos_d     = pos_q;
    dropped_d = dropped_q;
    job_d     = 1'b0;
    qlen_d    = qlen_q;
    if (accept_i) begin
      unique case (cmd_i)
        CMD_CLEAR: begin
          count_d   = '0;
          base_d    = '0;
          pos_d     = '0;
          dropped_d = 1'b0;
        end
        CMD_LOAD: begin
          pos_d = pos_inc;
          if (last_element_i) begin
            pos_d = '0;
            if (room) begin
              count_d = count_q + CNW'(1);
              base_d  = base_q + AW'(MAX_FEATURES);
            end else begin
              dropped_d = 1'b1;
            end
          end
        end
        CMD_QUERY: begin
          pos_d = pos_inc;
          if (last_element_i) begin
            pos_d  = '0;
            job_d  = 1'b1;
            qlen_d = pos_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      base_q    <= '0;
      pos_q     <= '0;
      dropped_q <= 1'b0;
      job_q     <= 1'b0;
      qlen_q    <= '0;
    end else begin
      count_q   <= count_d;
      base_q    <= base_d;
      pos_q     <= pos_d;
      dropped_q <= dropped_d;
      job_q     <= job_d;
      qlen_q    <= qlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_query && slot_ok) begin
      qbuf_q[QW'(pos_q)] <= feature_value_i;
    end
  end

  assign qbuf_o        = qbuf_q;
  assign job_valid_o   = job_q;
  assign job_qlen_o    = qlen_q;
  assign job_count_o   = count_q;
  assign job_dropped_o = dropped_q;

endmodule

// ----- rtl/knnmc_back.sv -----
`timescale 1ns / 1ps
module knnmc_back import knnmc_pkg::*; #(
  parameter int unsigned MAX_REFERENCES = DefMaxReferences,
  parameter int unsigned MAX_FEATURES   = DefMaxFeatures,
  parameter int unsigned MAX_K          = DefMaxK,
  parameter int unsigned NUM_CLASSES    = DefNumClasses,
  localparam int unsigned AW  = (MAX_REFERENCES * MAX_FEATURES > 1) ?
                                $clog2(MAX_REFERENCES * MAX_FEATURES) : 1,
  localparam int unsigned RW  = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1,
  localparam int unsigned CNW = $clog2(MAX_REFERENCES + 1),
  localparam int unsigned PW  = $clog2(MAX_FEATURES + 1),
  localparam int unsigned QW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
  localparam int unsigned KW  = $clog2(MAX_K + 1),
  localparam int unsigned KIW = (MAX_K > 1) ? $clog2(MAX_K) : 1,
  localparam int unsigned CW  = $clog2(NUM_CLASSES + 1),
  localparam int unsigned CIW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
  localparam int unsigned VW  = $clog2(MAX_K + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fwe_i,
  input  logic [AW-1:0]           faddr_i,
  input  logic signed [FeatW-1:0] fdata_i,
  input  logic                    lwe_i,
  input  logic [RW-1:0]           laddr_i,
  input  logic [LabelW+PW-1:0]    ldata_i,
  input  logic signed [FeatW-1:0] qbuf_i [MAX_FEATURES],
  input  logic                    job_valid_i,
  input  logic [PW-1:0]           job_qlen_i,
  input  logic [CNW-1:0]          job_count_i,
  input  logic                    job_dropped_i,
  input  logic [KW-1:0]           k_i,
  input  logic [PW-1:0]           nf_i,
  input  logic [CW-1:0]           nc_i,
  input  logic                    res_full_i,
  output logic                    busy_o,
  output logic                    res_valid_o,
  output result_t                 res_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_DIFF = 3'd2;
  localparam logic [2:0] S_MAC  = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;
  localparam logic [2:0] S_VOTE = 3'd5;
  localparam logic [2:0] S_PICK = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic signed [FeatW-1:0]  fmem [MAX_REFERENCES * MAX_FEATURES];
  logic [LabelW+PW-1:0]     lmem [MAX_REFERENCES];
  logic signed [FeatW-1:0]  frd_q;
  logic [LabelW+PW-1:0]     lrd_q;

  logic [2:0]        state_q, state_d;
  logic [CNW-1:0]    r_q, r_d, count_q;
  logic [PW-1:0]     j_q, j_d, qlen_q;
  logic [AW-1:0]     base_q, base_d;
  logic              dropped_q;
  logic signed [FeatW:0] diff_q, diff_d;
  logic [DistW-1:0]  acc_q, acc_d;
  logic signed [2*FeatW+1:0] prod;
  logic [DistW-1:0]  best_dist_q [MAX_K];
  logic [LabelW-1:0] best_lbl_q  [MAX_K];
  logic [VW-1:0]     votes_q [NUM_CLASSES];
  logic [KW-1:0]     vj_q;
  logic [CW-1:0]     c_q;
  logic [CIW-1:0]    win_q;
  logic [VW-1:0]     win_votes_q;
  logic [KIW-1:0]    kidx;
  logic [LabelW-1:0] vlbl;
  logic              le [MAX_K];
  logic signed [FeatW-1:0] qval, rval;

  always_ff @(posedge clk_i) begin
    if (fwe_i) begin
      fmem[faddr_i] <= fdata_i;
    end
    frd_q <= fmem[base_q + AW'(j_q)];
  end

  always_ff @(posedge clk_i) begin
    if (lwe_i) begin
      lmem[laddr_i] <= ldata_i;
    end
    if (state_q == S_RD && j_q == '0) begin
      lrd_q <= lmem[RW'(r_q)];
    end
  end

  assign kidx = KIW'(k_i - KW'(1));
  assign qval = (j_q < qlen_q) ? qbuf_i[QW'(j_q)] : '0;
  assign rval = (j_q < lrd_q[PW-1:0]) ? frd_q : '0;
  assign diff_d = (FeatW+1)'(qval) - (FeatW+1)'(rval);
  assign prod = diff_q * diff_q;
  assign acc_d = acc_q + DistW'(prod[2*FeatW-1:0]);
  assign vlbl = best_lbl_q[KIW'(vj_q)];

  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      le[i] = (KW'(i) < k_i) && (best_dist_q[i] <= acc_q);
    end
  end

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    j_d     = j_q;
    base_d  = base_q;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          r_d = '0;
          j_d = '0;
          base_d = '0;
          state_d = (job_count_i == '0) ? S_VOTE : S_RD;
        end
      end
      S_RD:   state_d = S_DIFF;
      S_DIFF: state_d = S_MAC;
      S_MAC: begin
        if (j_q + PW'(1) == nf_i) begin
          state_d = S_INS;
        end else begin
          j_d = j_q + PW'(1);
          state_d = S_RD;
        end
      end
      S_INS: begin
        j_d = '0;
        r_d = r_q + CNW'(1);
        base_d = base_q + AW'(MAX_FEATURES);
        state_d = (r_q + CNW'(1) == count_q) ? S_VOTE : S_RD;
      end
      S_VOTE: begin
        if (vj_q + KW'(1) == k_i) begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        if (c_q >= nc_i) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!res_full_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      r_q     <= '0;
      j_q     <= '0;
      base_q  <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      j_q     <= j_d;
      base_q  <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        count_q   <= job_count_i;
        qlen_q    <= job_qlen_i;
        dropped_q <= job_dropped_i;
        acc_q     <= '0;
        vj_q      <= '0;
        for (int i = 0; i < MAX_K; i++) begin
          best_dist_q[i] <= '1;
          best_lbl_q[i]  <= '0;
        end
        for (int i = 0; i < NUM_CLASSES; i++) begin
          votes_q[i] <= '0;
        end
      end
      S_DIFF: diff_q <= diff_d;
      S_MAC:  acc_q <= acc_d;
      S_INS: begin
        acc_q <= '0;
        if (acc_q < best_dist_q[kidx]) begin
          for (int i = 0; i < MAX_K; i++) begin
            if (!le[i]) begin
              if (i == 0 || le[(i == 0) ? 0 : i-1]) begin
                best_dist_q[i] <= acc_q;
                best_lbl_q[i]  <= lrd_q[LabelW+PW-1:PW];
              end else begin
                best_dist_q[i] <= best_dist_q[(i == 0) ? 0 : i-1];
                best_lbl_q[i]  <= best_lbl_q[(i == 0) ? 0 : i-1];
              end
            end
          end
        end
      end
      S_VOTE: begin
        vj_q <= vj_q + KW'(1);
        if (CW'(vlbl) < nc_i) begin
          votes_q[CIW'(vlbl)] <= votes_q[CIW'(vlbl)] + VW'(1);
        end
        c_q <= CW'(1);
        win_q <= '0;
      end
      S_PICK: begin
        if (c_q == CW'(1)) begin
          win_votes_q <= votes_q[0];
        end
        if (c_q < nc_i && votes_q[CIW'(c_q)] >
            ((c_q == CW'(1)) ? votes_q[0] : win_votes_q)) begin
          win_q       <= CIW'(c_q);
          win_votes_q <= votes_q[CIW'(c_q)];
        end
        c_q <= c_q + CW'(1);
      end
      default: ;
    endcase
  end

  assign busy_o      = state_q != S_IDLE;
  assign res_valid_o = (state_q == S_OUT) && !res_full_i;
  assign res_o.predicted_class    = LabelW'(win_q);
  assign res_o.vote_count         = VoteW'(win_votes_q);
  assign res_o.references_dropped = dropped_q;

endmodule

// ----- rtl/knnmc_fifo.sv -----
`timescale 1ns / 1ps
module knnmc_fifo import knnmc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  result_t wdata_i,
  output logic    full_o,
  input  logic    rd_i,
  output logic    empty_o,
  output result_t rdata_o
);

  result_t    mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= ~wp_q;
      if (rd_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr_i) - 2'(rd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rp_q];

endmodule

// ----- rtl/knn_majority_classifier.sv -----
// Feature elements of reference and query vectors are taken one per cycle while full is
// low. After the last element of a query, full stays high while the stored references are
// scanned: each reference takes a read, difference and multiply-accumulate step per
// feature in use plus a sorted insertion, all through the single read port of the reference
// memory, then the k nearest are voted on and the winner picked. Results wait in a two-entry queue.
`timescale 1ns / 1ps
module knn_majority_classifier import knnmc_pkg::*; #(
  parameter int unsigned MAX_REFERENCES = DefMaxReferences,
  parameter int unsigned MAX_FEATURES   = DefMaxFeatures,
  parameter int unsigned MAX_K          = DefMaxK,
  parameter int unsigned NUM_CLASSES    = DefNumClasses
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [CmdW-1:0]         cmd_i,
  input  logic signed [FeatW-1:0] feature_value_i,
  input  logic [LabelW-1:0]       label_i,
  input  logic                    last_element_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [LabelW-1:0]       predicted_class_o,
  output logic [VoteW-1:0]        vote_count_o,
  output logic                    references_dropped_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CfgW-1:0]         cfg_data_i
);

  localparam int unsigned AW  = (MAX_REFERENCES * MAX_FEATURES > 1) ?
                                $clog2(MAX_REFERENCES * MAX_FEATURES) : 1;
  localparam int unsigned RW  = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
  localparam int unsigned CNW = $clog2(MAX_REFERENCES + 1);
  localparam int unsigned PW  = $clog2(MAX_FEATURES + 1);
  localparam int unsigned KW  = $clog2(MAX_K + 1);
  localparam int unsigned CW  = $clog2(NUM_CLASSES + 1);

  logic [CfgW-1:0] k_q, nf_q, nc_q;
  logic [KW-1:0]   k_eff;
  logic [PW-1:0]   nf_eff;
  logic [CW-1:0]   nc_eff;
  logic            accept, busy, res_valid, res_full;
  logic            fwe, lwe, job_valid, job_dropped;
  logic [AW-1:0]   faddr;
  logic signed [FeatW-1:0] fdata;
  logic [RW-1:0]   laddr;
  logic [LabelW+PW-1:0] ldata;
  logic signed [FeatW-1:0] qbuf [MAX_FEATURES];
  logic [PW-1:0]   job_qlen;
  logic [CNW-1:0]  job_count;
  result_t         res, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= CfgW'(1);
      nf_q <= CfgW'(16);
      nc_q <= CfgW'(16);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_K:        k_q  <= cfg_data_i;
        REG_FEATURES: nf_q <= cfg_data_i;
        REG_CLASSES:  nc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign k_eff  = (k_q == '0) ? KW'(1) :
                  (32'(k_q) > MAX_K) ? KW'(MAX_K) : KW'(k_q);
  assign nf_eff = (nf_q == '0) ? PW'(1) :
                  (32'(nf_q) > MAX_FEATURES) ? PW'(MAX_FEATURES) : PW'(nf_q);
  assign nc_eff = (nc_q == '0) ? CW'(1) :
                  (32'(nc_q) > NUM_CLASSES) ? CW'(NUM_CLASSES) : CW'(nc_q);

  assign full   = busy || job_valid;
  assign accept = push && !full;

  knnmc_front #(
    .MAX_REFERENCES(MAX_REFERENCES),
    .MAX_FEATURES  (MAX_FEATURES)
  ) u_front (
    .clk_i, .rst_ni,
    .accept_i       (accept),
    .cmd_i, .feature_value_i, .label_i, .last_element_i,
    .fwe_o          (fwe),
    .faddr_o        (faddr),
    .fdata_o        (fdata),
    .lwe_o          (lwe),
    .laddr_o        (laddr),
    .ldata_o        (ldata),
    .qbuf_o         (qbuf),
    .job_valid_o    (job_valid),
    .job_qlen_o     (job_qlen),
    .job_count_o    (job_count),
    .job_dropped_o  (job_dropped)
  );

  knnmc_back #(
    .MAX_REFERENCES(MAX_REFERENCES),
    .MAX_FEATURES  (MAX_FEATURES),
    .MAX_K         (MAX_K),
    .NUM_CLASSES   (NUM_CLASSES)
  ) u_back (
    .clk_i, .rst_ni,
    .fwe_i          (fwe),
    .faddr_i        (faddr),
    .fdata_i        (fdata),
    .lwe_i          (lwe),
    .laddr_i        (laddr),
    .ldata_i        (ldata),
    .qbuf_i         (qbuf),
    .job_valid_i    (job_valid),
    .job_qlen_i     (job_qlen),
    .job_count_i    (job_count),
    .job_dropped_i  (job_dropped),
    .k_i            (k_eff),
    .nf_i           (nf_eff),
    .nc_i           (nc_eff),
    .res_full_i     (res_full),
    .busy_o         (busy),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  knnmc_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_i    (res_valid),
    .wdata_i (res),
    .full_o  (res_full),
    .rd_i    (pop && !empty),
    .empty_o (empty),
    .rdata_o (head)
  );

  assign predicted_class_o    = head.predicted_class;
  assign vote_count_o         = head.vote_count;
  assign references_dropped_o = head.references_dropped;

  a_no_accept_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !accept) else $error("request accepted during a scan");

  a_job_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid |=> busy) else $error("query did not start a scan");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !res_full) else $error("result queue overflow");

  a_votes_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (32'(res.vote_count) <= MAX_K)) else $error("vote count too large");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import knnmc_pkg::*;

  localparam int unsigned LibDepth  = DefMaxReferences;
  localparam int unsigned SlotCount = DefMaxFeatures;
  localparam int unsigned KMax      = DefMaxK;
  localparam int unsigned ClassMax  = DefNumClasses;
  localparam longint unsigned DistFar = (64'd1 << DistW) - 1;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned SettleCycles = 40;

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  logic [CmdW-1:0] cmd_i;
  logic signed [FeatW-1:0] feature_value_i;
  logic [LabelW-1:0] label_i;
  logic last_element_i;
  logic empty;
  logic pop;
  logic [LabelW-1:0] predicted_class_o;
  logic [VoteW-1:0] vote_count_o;
  logic references_dropped_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0] cfg_data_i;

  knn_majority_classifier uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .cmd_i(cmd_i),
    .feature_value_i(feature_value_i),
    .label_i(label_i),
    .last_element_i(last_element_i),
    .empty(empty),
    .pop(pop),
    .predicted_class_o(predicted_class_o),
    .vote_count_o(vote_count_o),
    .references_dropped_o(references_dropped_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  logic signed [FeatW-1:0] lib_feat [LibDepth][SlotCount];
  logic [LabelW-1:0] lib_label [LibDepth];
  int unsigned lib_count;
  int unsigned slot_pos;
  logic signed [FeatW-1:0] query_vec [SlotCount];
  bit lost_flag;
  logic [CfgW-1:0] k_reg, nf_reg, nc_reg;

  result_t pending_votes[$];
  int unsigned error_count;
  int unsigned cycle_count;
  bit quiet;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic report(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int unsigned clamp_reg(logic [CfgW-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic result_t classify_query();
    longint unsigned kept_dist [KMax];
    logic [LabelW-1:0] labs [KMax];
    int unsigned votes [ClassMax];
    int unsigned k, nf, nc, best, j;
    longint unsigned d, td;
    longint signed diff;
    logic [LabelW-1:0] tl;
    result_t res;
    k = clamp_reg(k_reg, KMax);
    nf = clamp_reg(nf_reg, SlotCount);
    nc = clamp_reg(nc_reg, ClassMax);
    for (int i = 0; i < KMax; i++) begin
      kept_dist[i] = DistFar;
      labs[i] = '0;
    end
    for (int r = 0; r < lib_count; r++) begin
      d = 0;
      for (int f = 0; f < nf; f++) begin
        diff = longint'(query_vec[f]) - longint'(lib_feat[r][f]);
        d += diff * diff;
      end
      if (d < kept_dist[k-1]) begin
        kept_dist[k-1] = d;
        labs[k-1] = lib_label[r];
        for (j = k - 1; j > 0; j--) begin
          if (kept_dist[j] >= kept_dist[j-1]) break;
          td = kept_dist[j]; kept_dist[j] = kept_dist[j-1]; kept_dist[j-1] = td;
          tl = labs[j]; labs[j] = labs[j-1]; labs[j-1] = tl;
        end
      end
    end
    for (int i = 0; i < ClassMax; i++) votes[i] = 0;
    for (int i = 0; i < k; i++) if (labs[i] < nc) votes[labs[i]]++;
    best = 0;
    for (int i = 1; i < nc; i++) if (votes[i] > votes[best]) best = i;
    res.predicted_class = LabelW'(best);
    res.vote_count = VoteW'(votes[best]);
    res.references_dropped = lost_flag;
    return res;
  endfunction

  task automatic absorb_request(cmd_e c, logic signed [FeatW-1:0] fv,
                                logic [LabelW-1:0] lb, logic lst);
    bit room;
    case (c)
      CMD_CLEAR: begin
        lib_count = 0;
        slot_pos = 0;
        lost_flag = 1'b0;
      end
      CMD_LOAD: begin
        room = lib_count < LibDepth;
        if (room && slot_pos < SlotCount) lib_feat[lib_count][slot_pos] = fv;
        if (slot_pos < SlotCount) slot_pos++;
        if (lst) begin
          if (room) begin
            for (int p = slot_pos; p < SlotCount; p++) lib_feat[lib_count][p] = '0;
            lib_label[lib_count] = lb;
            lib_count++;
          end else begin
            lost_flag = 1'b1;
          end
          slot_pos = 0;
        end
      end
      CMD_QUERY: begin
        if (slot_pos < SlotCount) begin
          query_vec[slot_pos] = fv;
          slot_pos++;
        end
        if (lst) begin
          for (int p = slot_pos; p < SlotCount; p++) query_vec[p] = '0;
          slot_pos = 0;
          pending_votes.push_back(classify_query());
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(cmd_e c, logic signed [FeatW-1:0] fv,
                           logic [LabelW-1:0] lb, logic lst);
    if (!quiet && $urandom_range(99) < 9) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    push <= 1'b1;
    cmd_i <= c;
    feature_value_i <= fv;
    label_i <= lb;
    last_element_i <= lst;
    do @(posedge clk_i); while (full);
    absorb_request(c, fv, lb, lst);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_votes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_K: k_reg = val;
      REG_FEATURES: nf_reg = val;
      REG_CLASSES: nc_reg = val;
      default: begin
      end
    endcase
  endtask

  task automatic set_config(logic [CfgW-1:0] k, logic [CfgW-1:0] nf, logic [CfgW-1:0] nc);
    drain();
    write_reg(REG_K, k);
    write_reg(REG_FEATURES, nf);
    write_reg(REG_CLASSES, nc);
  endtask

  function automatic logic [FeatW-1:0] pick_feature();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(signed'($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vector(cmd_e c, int unsigned n, logic [LabelW-1:0] lb);
    for (int i = 0; i < n; i++) send_item(c, pick_feature(), lb, i == n - 1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_votes.size() == 0) begin
          report("result with nothing expected");
        end else begin
          if (predicted_class_o !== pending_votes[0].predicted_class)
            report($sformatf("predicted_class %0d, want %0d", predicted_class_o,
                             pending_votes[0].predicted_class));
          if (vote_count_o !== pending_votes[0].vote_count)
            report($sformatf("vote_count %0d, want %0d", vote_count_o,
                             pending_votes[0].vote_count));
          if (references_dropped_o !== pending_votes[0].references_dropped)
            report($sformatf("references_dropped %0b, want %0b", references_dropped_o,
                             pending_votes[0].references_dropped));
          void'(pending_votes.pop_front());
        end
      end
      pop <= quiet || ($urandom_range(99) >= 9);
    end
  end

  task automatic test_directed();
    send_item(CMD_QUERY, 16'sd5, 4'd0, 1'b1);
    set_config(5'd3, 5'd2, 5'd16);
    send_item(CMD_LOAD, 16'h8000, 4'd0, 1'b0);
    send_item(CMD_LOAD, 16'h8000, 4'd15, 1'b1);
    send_item(CMD_LOAD, 16'h7fff, 4'd5, 1'b1);
    send_item(CMD_LOAD, 16'sd1, 4'd0, 1'b0);
    send_item(CMD_NONE, 16'hffff, 4'd9, 1'b1);
    send_item(CMD_QUERY, 16'sd2, 4'd0, 1'b0);
    send_item(CMD_LOAD, 16'sd3, 4'd10, 1'b1);
    send_item(CMD_QUERY, 16'h7fff, 4'd0, 1'b0);
    send_item(CMD_QUERY, 16'h7fff, 4'd0, 1'b1);
    send_item(CMD_QUERY, 16'h8000, 4'd0, 1'b1);
    send_item(CMD_LOAD, 16'sd4, 4'd5, 1'b1);
    send_item(CMD_QUERY, 16'sd4, 4'd0, 1'b1);
    send_item(CMD_CLEAR, 16'sd0, 4'd0, 1'b0);
    send_item(CMD_QUERY, 16'sd0, 4'd0, 1'b1);
  endtask

  task automatic test_label_limits();
    set_config(5'd31, 5'd31, 5'd0);
    send_vector(CMD_LOAD, 18, 4'd3);
    send_vector(CMD_LOAD, 4, 4'd0);
    send_vector(CMD_QUERY, 17, 4'd0);
    set_config(5'd0, 5'd1, 5'd31);
    send_vector(CMD_QUERY, 1, 4'd0);
    set_config(5'd16, 5'd16, 5'd1);
    send_vector(CMD_QUERY, 16, 4'd0);
  endtask

  task automatic test_full_store();
    set_config(5'd16, 5'd1, 5'd16);
    send_item(CMD_CLEAR, 16'sd0, 4'd0, 1'b0);
    for (int i = 0; i <= LibDepth; i++)
      send_item(CMD_LOAD, pick_feature(), 4'($urandom), 1'b1);
    send_item(CMD_QUERY, 16'sd0, 4'd0, 1'b1);
    drain();
    send_item(CMD_CLEAR, 16'sd0, 4'd0, 1'b0);
    send_item(CMD_QUERY, 16'sd0, 4'd0, 1'b1);
  endtask

  task automatic test_random(int unsigned items);
    int unsigned sent, n, nf, roll;
    logic [CfgW-1:0] ks [8] = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd7, 5'd16, 5'd31};
    logic [CfgW-1:0] ns [6] = '{5'd0, 5'd1, 5'd2, 5'd4, 5'd16, 5'd31};
    sent = 0;
    while (sent < items) begin
      if (sent % 40 < 8)
        set_config(ks[$urandom_range(7)], ns[$urandom_range(5)], 5'($urandom));
      if (sent % 60 < 8) begin
        drain();
        repeat (1) @(posedge clk_i);
      end
      quiet = (sent > 30 && sent < 80);
      nf = clamp_reg(nf_reg, SlotCount);
      if (lib_count >= 40) begin
        send_item(CMD_CLEAR, pick_feature(), 4'($urandom), 1'($urandom));
        sent++;
      end
      roll = $urandom_range(99);
      n = ($urandom_range(9) == 0) ? $urandom_range(1, 19) : $urandom_range(1, nf);
      if (roll < 60) begin
        send_vector(CMD_LOAD, n, 4'($urandom));
      end else if (roll < 88) begin
        send_vector(CMD_QUERY, n, 4'($urandom));
      end else if (roll < 94) begin
        send_item(CMD_NONE, pick_feature(), 4'($urandom), 1'($urandom));
        n = 0;
      end else begin
        for (int i = 0; i < n; i++)
          send_item($urandom_range(1) ? CMD_LOAD : CMD_QUERY, pick_feature(),
                    4'($urandom), i == n - 1);
      end
      sent += n;
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    cmd_i = CMD_NONE;
    feature_value_i = '0;
    label_i = '0;
    last_element_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_K;
    cfg_data_i = '0;
    cycle_count = 0;
    error_count = 0;
    quiet = 1'b0;
    lib_count = 0;
    slot_pos = 0;
    lost_flag = 1'b0;
    k_reg = 5'd1;
    nf_reg = 5'd16;
    nc_reg = 5'd16;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_full_store();
    test_directed();
    test_label_limits();
    drain();
    write_reg(REG_NONE, 5'd9);
    test_random(100);
    drain();
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/knnmc_pkg.sv
rtl/knnmc_front.sv
rtl/knnmc_back.sv
rtl/knnmc_fifo.sv
rtl/knn_majority_classifier.sv
verif/tb_top.sv
